FILE: sv/tusa_pkg.sv
// ============================================================================
// tusa_pkg
// Shared types and constants of the texture unit slot allocator.
// ============================================================================
package tusa_pkg;

    // Field widths of the input and result words.
    localparam int ID_W      = 32;
    localparam int UNIT_W    = 5;
    localparam int USE_W     = 6;
    localparam int CFG_W     = 6;
    localparam int REQ_W     = 2;

    // Stream payload widths, packed from bit zero up; tdata padded to bytes.
    localparam int S_TDATA_W = 3 * ID_W;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    // Register port.
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam logic REG_IDX_MAX_UNITS = 1'b0;

    localparam logic [CFG_W-1:0] MAX_UNITS_RST = 6'd16;

    // Request kinds carried in s_tuser.
    typedef enum logic [REQ_W-1:0] {
        REQ_SUBMIT = 2'd0,
        REQ_FLUSH  = 2'd1,
        REQ_BEGIN  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

endpackage

FILE: sv/texture_unit_slot_allocator_top.sv
// ============================================================================
// texture_unit_slot_allocator_top
// Binds texture ids to a small table of texture units, three ids per word.
// ============================================================================
// Path: input register, then result register. Throughput: one word per
// cycle unless the result stalls; the bound-id table is compared in parallel
// against all three ids and updated in the same cycle the result is formed.
// Reset (aresetn low, synchronous) empties the table, drops both valid flags
// and sets max_units to 16. The stored ids themselves are not cleared.
module texture_unit_slot_allocator_top #(
    parameter int MAX_UNITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: tex_id_a [31:0], tex_id_b [63:32], tex_id_c [95:64]
    input  logic [tusa_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: req_type [1:0]
    input  logic [tusa_pkg::REQ_W-1:0]     s_tuser,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata: unit_a [4:0], unit_b [9:5], unit_c [14:10], units_in_use [20:15],
    //        zero padding [23:21]
    output logic [tusa_pkg::M_TDATA_W-1:0] m_tdata,
    // tuser: flushed [0]
    output logic [tusa_pkg::M_TUSER_W-1:0] m_tuser,
    // Register port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tusa_pkg::PADDR_W-1:0]   paddr,
    input  logic [tusa_pkg::PDATA_W-1:0]   pwdata,
    output logic [tusa_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import tusa_pkg::*;

    // Index of one table entry, and a count that can also hold MAX_UNITS.
    localparam int IDX_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int CNT_W = $clog2(MAX_UNITS + 1);
    // Width that holds count plus misses as well as the configured limit.
    localparam int SUM_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_UNITS);

    // ------------------------------------------------------------------
    // Configuration register. pready is tied high, so the write lands on
    // the access cycle.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] max_units_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_MAX_UNITS);
    assign prdata = (paddr[2] == REG_IDX_MAX_UNITS)
                    ? {{(PDATA_W-CFG_W){1'b0}}, max_units_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_units_reg <= MAX_UNITS_RST;
        end else if (cfg_wr) begin
            max_units_reg <= pwdata[CFG_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Input register. The stage moves whenever the result register is
    // empty or its word is being taken.
    // ------------------------------------------------------------------
    logic            in_valid_reg;
    req_t            in_req_reg;
    logic [ID_W-1:0] in_a_reg;
    logic [ID_W-1:0] in_b_reg;
    logic [ID_W-1:0] in_c_reg;
    logic            out_valid_reg;
    logic            advance;
    logic            fire;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_req_reg <= req_t'(s_tuser);
            in_a_reg   <= s_tdata[ID_W-1:0];
            in_b_reg   <= s_tdata[2*ID_W-1:ID_W];
            in_c_reg   <= s_tdata[3*ID_W-1:2*ID_W];
        end
    end

    // ------------------------------------------------------------------
    // Bound-id table. Every entry is compared against the three ids at
    // once; only entries below the count take part.
    // ------------------------------------------------------------------
    logic [ID_W-1:0]      bound_ids_reg [MAX_UNITS];
    logic [CNT_W-1:0]     bound_count_reg;
    logic [CNT_W-1:0]     bound_count_next;
    logic [MAX_UNITS-1:0] hit_a;
    logic [MAX_UNITS-1:0] hit_b;
    logic [MAX_UNITS-1:0] hit_c;

    always_comb begin
        for (int e = 0; e < MAX_UNITS; e++) begin
            hit_a[e] = (CNT_W'(e) < bound_count_reg) && (bound_ids_reg[e] == in_a_reg);
            hit_b[e] = (CNT_W'(e) < bound_count_reg) && (bound_ids_reg[e] == in_b_reg);
            hit_c[e] = (CNT_W'(e) < bound_count_reg) && (bound_ids_reg[e] == in_c_reg);
        end
    end

    // Lowest matching entry, as the table is searched from unit zero up.
    function automatic logic [IDX_W-1:0] first_hit(input logic [MAX_UNITS-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = MAX_UNITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

    // A duplicate that is not bound still counts as a miss of its own.
    logic [1:0]       misses;
    logic [SUM_W-1:0] need;
    logic [SUM_W-1:0] limit;
    logic             over_limit;

    assign misses     = 2'(!(|hit_a)) + 2'(!(|hit_b)) + 2'(!(|hit_c));
    assign need       = SUM_W'(bound_count_reg) + SUM_W'(misses);
    assign limit      = (SUM_W'(max_units_reg) > SUM_W'(MAX_UNITS))
                        ? SUM_W'(MAX_UNITS) : SUM_W'(max_units_reg);
    assign over_limit = need > limit;

    // ------------------------------------------------------------------
    // Allocation. After a forced flush the table counts as empty, so every
    // id is new. A new id takes the next free unit unless it repeats an id
    // placed earlier in the same word; once the table is full, a new id
    // gets unit zero and is not stored.
    // ------------------------------------------------------------------
    logic             flushed_c;
    logic [CNT_W-1:0] unit_a_c;
    logic [CNT_W-1:0] unit_b_c;
    logic [CNT_W-1:0] unit_c_c;
    logic             we_a;
    logic             we_b;
    logic             we_c;
    logic [CNT_W-1:0] slot_a;
    logic [CNT_W-1:0] slot_b;
    logic [CNT_W-1:0] slot_c;

    always_comb begin
        logic [CNT_W-1:0] c0;
        logic [CNT_W-1:0] c1;
        logic [CNT_W-1:0] c2;
        logic [CNT_W-1:0] c3;
        logic             fa;
        logic             fb;
        logic             fc;

        bound_count_next = bound_count_reg;
        flushed_c        = 1'b0;
        unit_a_c         = '0;
        unit_b_c         = '0;
        unit_c_c         = '0;
        we_a             = 1'b0;
        we_b             = 1'b0;
        we_c             = 1'b0;
        c0               = over_limit ? '0 : bound_count_reg;
        c1               = c0;
        c2               = c0;
        c3               = c0;
        fa               = (|hit_a) && !over_limit;
        fb               = (|hit_b) && !over_limit;
        fc               = (|hit_c) && !over_limit;

        case (in_req_reg)
            REQ_SUBMIT: begin
                flushed_c = over_limit;

                if (fa) begin
                    unit_a_c = CNT_W'(first_hit(hit_a));
                end else if (c0 < MAX_CNT) begin
                    we_a     = 1'b1;
                    unit_a_c = c0;
                    c1       = c0 + CNT_W'(1);
                end
                c2 = c1;

                if (fb) begin
                    unit_b_c = CNT_W'(first_hit(hit_b));
                end else if (we_a && (in_b_reg == in_a_reg)) begin
                    unit_b_c = unit_a_c;
                end else if (c1 < MAX_CNT) begin
                    we_b     = 1'b1;
                    unit_b_c = c1;
                    c2       = c1 + CNT_W'(1);
                end
                c3 = c2;

                if (fc) begin
                    unit_c_c = CNT_W'(first_hit(hit_c));
                end else if (we_a && (in_c_reg == in_a_reg)) begin
                    unit_c_c = unit_a_c;
                end else if (we_b && (in_c_reg == in_b_reg)) begin
                    unit_c_c = unit_b_c;
                end else if (c2 < MAX_CNT) begin
                    we_c     = 1'b1;
                    unit_c_c = c2;
                    c3       = c2 + CNT_W'(1);
                end

                bound_count_next = c3;
            end
            REQ_FLUSH: begin
                bound_count_next = '0;
                flushed_c        = 1'b1;
            end
            REQ_BEGIN: begin
                bound_count_next = '0;
            end
            default: begin
                // An unused request code leaves the table untouched.
            end
        endcase

        slot_a = c0;
        slot_b = c1;
        slot_c = c2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_count_reg <= '0;
        end else if (fire) begin
            bound_count_reg <= bound_count_next;
        end
    end

    // The enabled write slots of one word are always distinct.
    always_ff @(posedge aclk) begin
        for (int e = 0; e < MAX_UNITS; e++) begin
            if (fire && we_a && (slot_a[IDX_W-1:0] == IDX_W'(e))) begin
                bound_ids_reg[e] <= in_a_reg;
            end else if (fire && we_b && (slot_b[IDX_W-1:0] == IDX_W'(e))) begin
                bound_ids_reg[e] <= in_b_reg;
            end else if (fire && we_c && (slot_c[IDX_W-1:0] == IDX_W'(e))) begin
                bound_ids_reg[e] <= in_c_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register. It holds its word until m_tready takes it.
    // ------------------------------------------------------------------
    logic              out_flushed_reg;
    logic [UNIT_W-1:0] out_unit_a_reg;
    logic [UNIT_W-1:0] out_unit_b_reg;
    logic [UNIT_W-1:0] out_unit_c_reg;
    logic [USE_W-1:0]  out_in_use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_flushed_reg <= flushed_c;
            out_unit_a_reg  <= UNIT_W'(unit_a_c);
            out_unit_b_reg  <= UNIT_W'(unit_b_c);
            out_unit_c_reg  <= UNIT_W'(unit_c_c);
            out_in_use_reg  <= USE_W'(bound_count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_flushed_reg;
    assign m_tdata  = {{(M_TDATA_W - 3*UNIT_W - USE_W){1'b0}}, out_in_use_reg,
                       out_unit_c_reg, out_unit_b_reg, out_unit_a_reg};

endmodule

FILE: sv/tusa_checker.sv
// ============================================================================
// tusa_checker
// Port-level checks of the texture unit slot allocator.
// ============================================================================
module tusa_checker #(
    parameter int MAX_UNITS = 32
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tusa_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [tusa_pkg::M_TUSER_W-1:0] m_tuser
);
    import tusa_pkg::*;

    logic [UNIT_W-1:0] unit_a;
    logic [USE_W-1:0]  in_use;

    assign unit_a = m_tdata[UNIT_W-1:0];
    assign in_use = m_tdata[3*UNIT_W+USE_W-1:3*UNIT_W];

    // A stalled result word keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Nothing is shown in the cycle after a reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("valid result after reset");

    // After a flush at most the three ids of the word can be bound.
    a_flush_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> in_use <= USE_W'(3))
        else $error("too many units in use after a flush");

    // Unit a is either zero or lies below the number of units in use.
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (unit_a == '0) || (USE_W'(unit_a) < in_use))
        else $error("unit number beyond units in use");

endmodule

bind texture_unit_slot_allocator_top tusa_checker #(.MAX_UNITS(MAX_UNITS)) u_tusa_checker (.*);

FILE: verif/texture_unit_slot_allocator_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// texture_unit_slot_allocator_top_tb
// Self-checking bench for the texture unit slot allocator. Words go in over
// the input stream with random bursts and gaps, and results are drained with
// a stalling receiver. A predictor that keeps its own copy of the bound-id
// table and the max_units register checks every result word field by field.
// ============================================================================
module texture_unit_slot_allocator_top_tb;
    import tusa_pkg::*;

    localparam int MAX_UNITS      = 32;
    // The settle time after the last result is scaled from the result latency.
    localparam int RESULT_LATENCY = 2;
    localparam int SETTLE_CYCLES  = 4 * RESULT_LATENCY;
    // Longest allowed run of cycles without any handshake. The longest
    // intended stall is the receiver hold in the back-pressure test.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int POOL_DEPTH     = 48;
    localparam logic [PADDR_W-1:0] MAX_UNITS_ADDR = {REG_IDX_MAX_UNITS, 2'b00};

    // One expected result word.
    typedef struct packed {
        logic              flushed;
        logic [UNIT_W-1:0] unit_a;
        logic [UNIT_W-1:0] unit_b;
        logic [UNIT_W-1:0] unit_c;
        logic [USE_W-1:0]  in_use;
    } bind_result_t;

    // How the result receiver paces m_tready.
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_style_t;

    // ------------------------------------------------------------------------
    // Block ports. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // tdata: tex_id_a [31:0], tex_id_b [63:32], tex_id_c [95:64]
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // tuser: req_type [1:0]
    logic [REQ_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // tdata: unit_a [4:0], unit_b [9:5], unit_c [14:10], units_in_use [20:15],
    //        zero padding [23:21]
    logic [M_TDATA_W-1:0] m_tdata;
    // tuser: flushed [0]
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    texture_unit_slot_allocator_top #(
        .MAX_UNITS (MAX_UNITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor state: the bound-id table, its fill count and the register.
    // Only entries below bound_count are ever looked at, so the table needs
    // no clearing at reset.
    // ------------------------------------------------------------------------
    logic [ID_W-1:0]  bound_ids [MAX_UNITS];
    int               bound_count   = 0;
    logic [CFG_W-1:0] max_units_cfg = MAX_UNITS_RST;

    bind_result_t     pending_binds [$];
    bind_result_t     bind_want;
    int               mismatches    = 0;
    int               idle_cycles   = 0;

    // Stimulus pacing.
    int               burst_left    = 0;
    bit               gaps_on       = 1'b1;
    rx_style_t        rx_style      = RX_ALWAYS;
    int               hold_req      = 0;
    int               stall_left    = 0;
    int               rx_phase      = 0;

    // Ids are mostly drawn from a small pool so that lookups hit often.
    logic [ID_W-1:0]  id_pool [POOL_DEPTH];
    int               pool_size     = 8;

    // Returns the unit that holds id, or -1 when it is not bound.
    function automatic int unit_of(input logic [ID_W-1:0] id);
        for (int i = 0; i < bound_count && i < MAX_UNITS; i++) begin
            if (bound_ids[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [UNIT_W-1:0] unit_field(input logic [ID_W-1:0] id);
        int u;
        u = unit_of(id);
        return (u < 0) ? '0 : u[UNIT_W-1:0];
    endfunction

    function automatic void bind_id(input logic [ID_W-1:0] id);
        if (unit_of(id) >= 0) begin
            return;
        end
        if (bound_count < MAX_UNITS) begin
            bound_ids[bound_count] = id;
            bound_count++;
        end
    endfunction

    // Applies one accepted word to the predicted table and returns the
    // result word the block must produce for it.
    function automatic bind_result_t bind_textures(input req_t req,
                                                   input logic [ID_W-1:0] ida,
                                                   input logic [ID_W-1:0] idb,
                                                   input logic [ID_W-1:0] idc);
        logic [ID_W-1:0] ids [3];
        bit              hit [3];
        int              misses;
        int              limit;
        bind_result_t    r;
        r      = '0;
        ids    = '{ida, idb, idc};
        misses = 0;
        case (req)
            REQ_SUBMIT: begin
                // The register saturates at the table size.
                limit = (max_units_cfg > MAX_UNITS) ? MAX_UNITS : int'(max_units_cfg);
                // Every copy of an unbound duplicate id counts as a miss.
                for (int i = 0; i < 3; i++) begin
                    hit[i] = unit_of(ids[i]) >= 0;
                    if (!hit[i]) begin
                        misses++;
                    end
                end
                if (bound_count + misses > limit) begin
                    bound_count = 0;
                    r.flushed   = 1'b1;
                end
                for (int i = 0; i < 3; i++) begin
                    if (r.flushed || !hit[i]) begin
                        bind_id(ids[i]);
                    end
                end
                r.unit_a = unit_field(ida);
                r.unit_b = unit_field(idb);
                r.unit_c = unit_field(idc);
            end
            REQ_FLUSH: begin
                bound_count = 0;
                r.flushed   = 1'b1;
            end
            REQ_BEGIN: begin
                bound_count = 0;
            end
            default: begin
            end
        endcase
        r.in_use = bound_count[USE_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge: register writes
    // first, then accepted input words feed the predictor, then accepted
    // result words are checked against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (psel && penable && pwrite && pready && paddr == MAX_UNITS_ADDR) begin
                max_units_cfg = pwdata[CFG_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                bind_want     = bind_textures(req_t'(s_tuser),
                                              s_tdata[ID_W-1:0],
                                              s_tdata[2*ID_W-1:ID_W],
                                              s_tdata[3*ID_W-1:2*ID_W]);
                pending_binds = {pending_binds, bind_want};
            end
            if (m_tvalid && m_tready) begin
                if (pending_binds.size() == 0) begin
                    $error("result word with no expectation waiting: tdata %h, tuser %h",
                           m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    bind_want = pending_binds.pop_front();
                    check_field("flushed", bind_want.flushed, m_tuser[0]);
                    check_field("unit_a", bind_want.unit_a, m_tdata[UNIT_W-1:0]);
                    check_field("unit_b", bind_want.unit_b, m_tdata[2*UNIT_W-1:UNIT_W]);
                    check_field("unit_c", bind_want.unit_c, m_tdata[3*UNIT_W-1:2*UNIT_W]);
                    check_field("units_in_use", bind_want.in_use,
                                m_tdata[3*UNIT_W+USE_W-1:3*UNIT_W]);
                    check_field("padding", 0, m_tdata[M_TDATA_W-1:3*UNIT_W+USE_W]);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog. Any handshake on either stream or the register port restarts
    // the count; a long silence means the block has hung.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result receiver. A hold request from a test takes priority and is
    // counted down here; otherwise m_tready follows the current style.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_req != 0) begin
            stall_left = hold_req;
            hold_req   = 0;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_style)
                RX_RANDOM:  m_tready <= ($urandom_range(0, 99) < 70);
                RX_PATTERN: m_tready <= ((rx_phase % 7) < 4);
                default:    m_tready <= 1'b1;
            endcase
        end
        rx_phase++;
    end

    // ------------------------------------------------------------------------
    // Drivers. Every task is entered just after a falling edge and returns
    // just after one, so each input changes at most once per edge.
    // ------------------------------------------------------------------------

    // Sends one word and waits for it to be accepted. Between bursts of
    // random length the sender drops s_tvalid for a random gap.
    task automatic send_word(input req_t req, input logic [ID_W-1:0] ida,
                             input logic [ID_W-1:0] idb, input logic [ID_W-1:0] idc);
        if (burst_left == 0) begin
            if (gaps_on) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {idc, idb, ida};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_max_units(input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_UNITS_ADDR;
        pwdata  <= PDATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stops sending and waits until every predicted result has come back,
    // then lets the pipeline settle so the block is idle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_binds.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // New pool of ids; the all-zeros and all-ones ids show up now and then.
    task automatic refill_pool(input int n);
        pool_size = n;
        for (int i = 0; i < n; i++) begin
            id_pool[i] = $urandom;
        end
        if ($urandom_range(0, 3) == 0) begin
            id_pool[0] = '0;
        end
        if ($urandom_range(0, 3) == 0) begin
            id_pool[n-1] = '1;
        end
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom;
        end
        return id_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    // Mostly submits, with the odd flush, begin and unused request kind.
    task automatic send_random_word();
        int   roll;
        req_t req;
        roll = $urandom_range(0, 99);
        if (roll < 90) begin
            req = REQ_SUBMIT;
        end else if (roll < 93) begin
            req = REQ_FLUSH;
        end else if (roll < 96) begin
            req = REQ_BEGIN;
        end else begin
            req = REQ_NONE;
        end
        send_word(req, pick_id(), pick_id(), pick_id());
    endtask

    task automatic pick_pacing();
        rx_style = rx_style_t'($urandom_range(0, 2));
        gaps_on  = 1'($urandom_range(0, 1));
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Runs with the reset value of max_units (16). Covers the all-zeros and
    // all-ones ids, duplicates inside one word, a fill exactly to the limit,
    // a forced flush one id past it, both clearing requests and the unused
    // request kind.
    task automatic test_directed();
        rx_style = RX_PATTERN;
        gaps_on  = 1'b1;
        send_word(REQ_SUBMIT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_word(REQ_SUBMIT, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(REQ_SUBMIT, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(REQ_NONE,   32'hAAAA_5555, 32'h5555_AAAA, 32'hFFFF_FFFF);
        // Four words of three new ids each take the table to 14.
        for (int k = 0; k < 4; k++) begin
            send_word(REQ_SUBMIT, 32'h1000_0000 + 3 * k, 32'h1000_0001 + 3 * k,
                      32'h1000_0002 + 3 * k);
        end
        // Two misses and one hit land exactly on the limit: no flush.
        send_word(REQ_SUBMIT, 32'h2000_0000, 32'h0000_0000, 32'h2000_0001);
        // One more miss goes past the limit and flushes first.
        send_word(REQ_SUBMIT, 32'h1000_0000, 32'h3000_0000, 32'h1000_0000);
        send_word(REQ_SUBMIT, 32'h1000_0000, 32'h3000_0000, 32'h2000_0000);
        send_word(REQ_FLUSH,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(REQ_SUBMIT, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_word(REQ_BEGIN,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_word(REQ_SUBMIT, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
        send_word(REQ_NONE,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_word(REQ_SUBMIT, 32'hAAAA_AAAA, 32'h0123_4567, 32'h89AB_CDEF);
    endtask

    // Walks max_units through its legal extremes and the out-of-range
    // values on both sides: below three, and above the table size where it
    // saturates. The id pool is sized so that the table can fill up.
    task automatic test_limit_sweep();
        logic [CFG_W-1:0] limits [10];
        int               pool_n;
        limits = '{6'd3, 6'd32, 6'd0, 6'd1, 6'd2, 6'd33, 6'd63, 6'd16, 6'd31, 6'd4};
        for (int i = 0; i < 10; i++) begin
            drain_results();
            write_max_units(limits[i]);
            pick_pacing();
            pool_n = (int'(limits[i]) + 6 > POOL_DEPTH) ? POOL_DEPTH : int'(limits[i]) + 6;
            refill_pool($urandom_range(3, pool_n));
            repeat (120) send_random_word();
        end
    endtask

    task automatic test_random_mix();
        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            write_max_units(CFG_W'($urandom_range(0, 63)));
            pick_pacing();
            refill_pool($urandom_range(3, POOL_DEPTH));
            repeat (100) send_random_word();
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words back to back, so the block fills and stalls its input.
    task automatic test_backpressure();
        drain_results();
        write_max_units(6'd32);
        refill_pool(20);
        rx_style = RX_ALWAYS;
        gaps_on  = 1'b0;
        hold_req = HOLD_CYCLES;
        repeat (80) send_random_word();
    endtask

    initial begin
        // Reset is held at the start and released on a falling edge.
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_limit_sweep();
        test_random_mix();
        test_backpressure();

        drain_results();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
